[hdl/omw_pkg.sv]
`default_nettype none

package omw_pkg;

    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 18;
    localparam int DUTY_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd1194;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd34296;
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 16'hFFFF;

    localparam logic [15:0] STICK_X_CTR = 16'h8000;
    localparam logic [15:0] STICK_Y_CTR = 16'h7FFF;

    // divisor for 0.8 m/s at full trigger, and its half for rounding
    localparam logic [13:0] THR_DEN  = 14'd10230;
    localparam logic [12:0] THR_HALF = 13'd5115;

    // sqrt(3)/2 with 30 fraction bits
    localparam logic [29:0] SQ3H_Q30 = 30'd929887697;

    typedef struct packed {
        logic [GAIN_W-1:0]  pwm_gain;
        logic [LIMIT_W-1:0] speed_limit;
    } t_cfg;

endpackage

`default_nettype wire

[hdl/omw_div.sv]
`default_nettype none

module omw_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [PW-1:0] o_pass
);

    localparam int EW = NW + QW;

    logic [QW:0]   r_v;
    logic [NW-1:0] r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic [PW-1:0] r_pass [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_pass[0] <= i_pass;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int J = QW - 1 - k;
        logic [EW-1:0] n_dsh;
        logic          n_ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            n_dsh = EW'(r_den[k]) << J;
            n_ge  = EW'(r_rem[k]) >= n_dsh;
            n_rem = n_ge ? (r_rem[k] - n_dsh[NW-1:0]) : r_rem[k];
            n_q    = r_q[k];
            n_q[J] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_den[k+1]  <= r_den[k];
                r_q[k+1]    <= n_q;
                r_pass[k+1] <= r_pass[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quot  = r_q[QW];
    assign o_pass  = r_pass[QW];

endmodule

`default_nettype wire

[hdl/omw_sqrt.sv]
`default_nettype none

module omw_sqrt #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_val,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output logic [PW-1:0] o_pass
);

    // root of i_val * 2^32, one root bit per stage
    logic [32:0]   r_v;
    logic [63:0]   r_rem  [0:32];
    logic [31:0]   r_root [0:32];
    logic [PW-1:0] r_pass [0:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[31:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {i_val, 32'd0};
            r_root[0] <= '0;
            r_pass[0] <= i_pass;
        end
    end

    for (genvar k = 0; k < 32; k++) begin : g_stage
        localparam int I = 31 - k;
        logic [65:0] n_t;
        logic        n_ge;
        logic [63:0] n_rem;
        logic [31:0] n_root;

        // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
        always_comb begin
            n_t    = (66'(r_root[k]) << (I + 1)) + (66'(1) << (2 * I));
            n_ge   = 66'(r_rem[k]) >= n_t;
            n_rem  = n_ge ? (r_rem[k] - n_t[63:0]) : r_rem[k];
            n_root = r_root[k];
            n_root[I] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_pass[k+1] <= r_pass[k];
            end
        end
    end

    assign o_valid = r_v[32];
    assign o_root  = r_root[32];
    assign o_pass  = r_pass[32];

endmodule

`default_nettype wire

[hdl/omw_wheel.sv]
`default_nettype none

module omw_wheel #(
    parameter int SW        = 19,
    parameter int FRAC_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  omw_pkg::t_cfg            i_cfg,
    input  logic signed [SW-1:0]     i_sum,
    output logic                     o_reverse,
    output logic [omw_pkg::DUTY_W-1:0] o_duty
);

    import omw_pkg::*;

    localparam int MW = SW + 4;
    localparam int PRW = LIMIT_W + GAIN_W;

    logic signed [MW-1:0] n_w10;
    logic [MW-1:0]        n_wu;
    logic [MW-1:0]        n_mag;
    logic [PRW-1:0]       n_sh;

    logic                 r_neg1, r_neg2, r_neg3;
    logic [MW-1:0]        r_mag1;
    logic [LIMIT_W-1:0]   r_lim2;
    logic [PRW-1:0]       r_prod3;

    always_comb begin
        n_w10 = (MW'(i_sum) <<< 3) + (MW'(i_sum) <<< 1);
        n_wu  = n_w10;
        n_mag = n_wu[MW-1] ? (~n_wu + MW'(1)) : n_wu;
        n_sh  = r_prod3 >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1  <= n_wu[MW-1];
            r_mag1  <= n_mag;
            r_neg2  <= r_neg1;
            r_lim2  <= (r_mag1 > MW'(i_cfg.speed_limit)) ? i_cfg.speed_limit
                                                         : r_mag1[LIMIT_W-1:0];
            r_neg3  <= r_neg2;
            r_prod3 <= PRW'(r_lim2) * PRW'(i_cfg.pwm_gain);
            o_reverse <= r_neg3;
            o_duty    <= (n_sh > PRW'(DUTY_MAX)) ? DUTY_MAX : n_sh[DUTY_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/omni_wheel_drive_mixer.sv]
`default_nettype none

// Four-wheel omni drive mixer. Each gamepad command (triggers, right stick,
// yaw rate) becomes four wheel drives: a reverse bit and a 16-bit PWM compare
// value. Throttle is right minus left trigger scaled to 0.8 m/s, steered by the
// unit stick direction, mixed for the wheels, clamped to speed_limit and
// scaled by pwm_gain. One command is accepted every cycle unless stalled; the
// throttle divider, the 32-stage square root and the direction divider each
// give one bit per stage. A stall with a valid word at the output freezes the
// whole pipeline. Registers are written through the config port, always ready;
// the user must write them only with no command in flight: it is not enforced.
module omni_wheel_drive_mixer #(
    parameter int FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [omw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [omw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [9:0]                    i_left_trigger,
    input  logic [9:0]                    i_right_trigger,
    input  logic [15:0]                   i_stick_x,
    input  logic [15:0]                   i_stick_y,
    input  logic signed [15:0]            i_yaw_rate,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_wheel0_reverse,
    output logic [15:0]                   o_wheel0_duty,
    output logic                          o_wheel1_reverse,
    output logic [15:0]                   o_wheel1_duty,
    output logic                          o_wheel2_reverse,
    output logic [15:0]                   o_wheel2_duty,
    output logic                          o_wheel3_reverse,
    output logic [15:0]                   o_wheel3_duty
);

    import omw_pkg::*;

    localparam int TW     = FRAC_BITS + 1;
    localparam int THR_NW = FRAC_BITS + 14;
    localparam int VX_NW  = TW + 34;
    localparam int TP_W   = 32 + 1 + 1 + 16 + 1 + 16 + 16;
    localparam int SP_PW  = 1 + TW + 1 + 1 + 16 + 1 + 16 + 16;
    localparam int XP_PW  = 1 + TW + 1 + 1 + 16;
    localparam int PR_W   = 16 + TW;
    localparam int SQ_W   = TW + 30;
    localparam int SW     = ((TW + 3 > 16) ? TW + 3 : 16) + 2;

    logic en;
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_gain    <= GAIN_RESET;
            r_cfg.speed_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PWM_GAIN:    r_cfg.pwm_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_LIMIT: r_cfg.speed_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage a: offsets and trigger difference
    logic [10:0] n_diff;
    logic [16:0] n_dx, n_dy;
    logic        r_a_v;
    logic        r_a_dneg, r_a_dxneg, r_a_dyneg;
    logic [9:0]  r_a_dmag;
    logic [15:0] r_a_dxmag, r_a_dymag;
    logic signed [15:0] r_a_yaw;

    always_comb begin
        n_diff = {1'b0, i_right_trigger} - {1'b0, i_left_trigger};
        n_dx   = {1'b0, STICK_X_CTR} - {1'b0, i_stick_x};
        n_dy   = {1'b0, STICK_Y_CTR} - {1'b0, i_stick_y};
    end

    // ---------------- stage b: squares and throttle numerator
    logic        r_b_v;
    logic        r_b_dneg, r_b_dxneg, r_b_dyneg;
    logic [15:0] r_b_dxmag, r_b_dymag;
    logic [31:0] r_b_sqx, r_b_sqy;
    logic [THR_NW-1:0] r_b_tnum;
    logic signed [15:0] r_b_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dneg  <= n_diff[10];
            r_a_dmag  <= n_diff[10] ? (~n_diff[9:0] + 10'd1) : n_diff[9:0];
            r_a_dxneg <= n_dx[16];
            r_a_dxmag <= n_dx[16] ? (~n_dx[15:0] + 16'd1) : n_dx[15:0];
            r_a_dyneg <= n_dy[16];
            r_a_dymag <= n_dy[16] ? (~n_dy[15:0] + 16'd1) : n_dy[15:0];
            r_a_yaw   <= i_yaw_rate;

            r_b_dneg  <= r_a_dneg;
            r_b_dxneg <= r_a_dxneg;
            r_b_dyneg <= r_a_dyneg;
            r_b_dxmag <= r_a_dxmag;
            r_b_dymag <= r_a_dymag;
            r_b_yaw   <= r_a_yaw;
            r_b_sqx   <= 32'(r_a_dxmag) * 32'(r_a_dxmag);
            r_b_sqy   <= 32'(r_a_dymag) * 32'(r_a_dymag);
            r_b_tnum  <= (THR_NW'(r_a_dmag) << (FRAC_BITS + 3)) + THR_NW'(THR_HALF);
        end
    end

    // ---------------- throttle magnitude
    logic [31:0]     n_c;
    logic            t_v;
    logic [TW-1:0]   t_tmag;
    logic [TP_W-1:0] t_pass;
    logic [31:0]     t_c;
    logic            t_dneg, t_dxneg, t_dyneg;
    logic [15:0]     t_dxmag, t_dymag;
    logic signed [15:0] t_yaw;

    assign n_c = r_b_sqx + r_b_sqy;

    omw_div #(
        .NW(THR_NW), .DW(14), .QW(TW), .PW(TP_W)
    ) u_thr_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_num   (r_b_tnum),
        .i_den   (THR_DEN),
        .i_pass  ({n_c, r_b_dneg, r_b_dxneg, r_b_dxmag, r_b_dyneg, r_b_dymag, r_b_yaw}),
        .o_valid (t_v),
        .o_quot  (t_tmag),
        .o_pass  (t_pass)
    );

    assign {t_c, t_dneg, t_dxneg, t_dxmag, t_dyneg, t_dymag, t_yaw} = t_pass;

    // ---------------- stick length
    logic             q_v;
    logic [31:0]      q_root;
    logic [SP_PW-1:0] q_pass;
    logic             q_czero, q_dneg, q_dxneg, q_dyneg;
    logic [TW-1:0]    q_tmag;
    logic [15:0]      q_dxmag, q_dymag;
    logic signed [15:0] q_yaw;

    omw_sqrt #(
        .PW(SP_PW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (t_v),
        .i_val   (t_c),
        .i_pass  ({(t_c == 32'd0), t_tmag, t_dneg, t_dxneg, t_dxmag,
                   t_dyneg, t_dymag, t_yaw}),
        .o_valid (q_v),
        .o_root  (q_root),
        .o_pass  (q_pass)
    );

    assign {q_czero, q_tmag, q_dneg, q_dxneg, q_dxmag, q_dyneg, q_dymag, q_yaw} = q_pass;

    // ---------------- stage p: direction products
    logic            r_p_v;
    logic [PR_W-1:0] r_p_px, r_p_py;
    logic [31:0]     r_p_m;
    logic            r_p_czero, r_p_dneg, r_p_dxneg, r_p_dyneg;
    logic [TW-1:0]   r_p_tmag;
    logic signed [15:0] r_p_yaw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_px    <= PR_W'(q_dymag) * PR_W'(q_tmag);
            r_p_py    <= PR_W'(q_dxmag) * PR_W'(q_tmag);
            r_p_m     <= q_root;
            r_p_czero <= q_czero;
            r_p_dneg  <= q_dneg;
            r_p_dxneg <= q_dxneg;
            r_p_dyneg <= q_dyneg;
            r_p_tmag  <= q_tmag;
            r_p_yaw   <= q_yaw;
        end
    end

    // ---------------- unit direction times throttle
    logic             x_v, y_v;
    logic [TW-1:0]    x_mx, y_my;
    logic [XP_PW-1:0] x_pass;
    logic             x_czero, x_dneg, x_dyneg, y_dxneg;
    logic [TW-1:0]    x_tmag;
    logic signed [15:0] x_yaw;

    omw_div #(
        .NW(VX_NW), .DW(33), .QW(TW), .PW(XP_PW)
    ) u_vx_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_v),
        .i_num   ((VX_NW'(r_p_px) << 17) + VX_NW'(r_p_m)),
        .i_den   ({r_p_m, 1'b0}),
        .i_pass  ({r_p_czero, r_p_tmag, r_p_dneg, r_p_dyneg, r_p_yaw}),
        .o_valid (x_v),
        .o_quot  (x_mx),
        .o_pass  (x_pass)
    );

    omw_div #(
        .NW(VX_NW), .DW(33), .QW(TW), .PW(1)
    ) u_vy_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_v),
        .i_num   ((VX_NW'(r_p_py) << 17) + VX_NW'(r_p_m)),
        .i_den   ({r_p_m, 1'b0}),
        .i_pass  (r_p_dxneg),
        .o_valid (y_v),
        .o_quot  (y_my),
        .o_pass  (y_dxneg)
    );

    assign {x_czero, x_tmag, x_dneg, x_dyneg, x_yaw} = x_pass;

    // ---------------- stage v: signed velocities
    logic               n_thrneg;
    logic signed [TW:0] n_thr, n_vxd, n_vx;
    logic               r_v_v;
    logic signed [TW:0] r_v_vx;
    logic [TW-1:0]      r_v_vymag;
    logic               r_v_vyneg;
    logic signed [15:0] r_v_yaw;

    always_comb begin
        n_thrneg = x_dneg && (x_tmag != '0);
        n_thr    = n_thrneg ? -$signed({1'b0, x_tmag}) : $signed({1'b0, x_tmag});
        n_vxd    = (x_dyneg ^ n_thrneg) ? -$signed({1'b0, x_mx}) : $signed({1'b0, x_mx});
        // centred stick drives straight ahead
        n_vx     = x_czero ? n_thr : n_vxd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_vx    <= n_vx;
            r_v_vymag <= x_czero ? '0 : y_my;
            r_v_vyneg <= y_dxneg ^ n_thrneg;
            r_v_yaw   <= x_yaw;
        end
    end

    // ---------------- stages s1, s2: twice 0.866 * vy
    logic               r_s1_v;
    logic [SQ_W-1:0]    r_s1_prod;
    logic signed [TW:0] r_s1_vx;
    logic               r_s1_vyneg;
    logic signed [15:0] r_s1_yaw;

    logic [SQ_W:0]        n_sr;
    logic [TW+1:0]        n_smag;
    logic                 r_s2_v;
    logic signed [TW+2:0] r_s2_s;
    logic signed [TW:0]   r_s2_vx;
    logic signed [15:0]   r_s2_yaw;

    always_comb begin
        n_sr   = (SQ_W + 1)'(r_s1_prod) + ((SQ_W + 1)'(1) << 28);
        n_smag = n_sr[SQ_W:29];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_prod  <= SQ_W'(r_v_vymag) * SQ_W'(SQ3H_Q30);
            r_s1_vx    <= r_v_vx;
            r_s1_vyneg <= r_v_vyneg;
            r_s1_yaw   <= r_v_yaw;

            r_s2_s   <= r_s1_vyneg ? -$signed({1'b0, n_smag}) : $signed({1'b0, n_smag});
            r_s2_vx  <= r_s1_vx;
            r_s2_yaw <= r_s1_yaw;
        end
    end

    // ---------------- stage m: wheel mix
    logic               r_m_v;
    logic signed [SW-1:0] r_m_sum [0:3];
    logic signed [SW-1:0] n_vxe, n_se, n_ye;

    always_comb begin
        n_vxe = SW'(r_s2_vx);
        n_se  = SW'(r_s2_s);
        n_ye  = SW'(r_s2_yaw);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_sum[0] <=  n_vxe - n_se - n_ye;
            r_m_sum[1] <=  n_vxe + n_se - n_ye;
            r_m_sum[2] <= -n_vxe + n_se - n_ye;
            r_m_sum[3] <= -n_vxe - n_se - n_ye;
        end
    end

    // valid through the tail stages and the four wheel stages
    logic [3:0] r_wv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v  <= 1'b0;
            r_v_v  <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_m_v  <= 1'b0;
            r_wv   <= '0;
        end else if (en) begin
            r_p_v  <= q_v;
            r_v_v  <= x_v & y_v;
            r_s1_v <= r_v_v;
            r_s2_v <= r_s1_v;
            r_m_v  <= r_s2_v;
            r_wv   <= {r_wv[2:0], r_m_v};
        end
    end

    logic              w_rev  [0:3];
    logic [DUTY_W-1:0] w_duty [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_wheel
        omw_wheel #(
            .SW(SW), .FRAC_BITS(FRAC_BITS)
        ) u_wheel (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_cfg     (r_cfg),
            .i_sum     (r_m_sum[k]),
            .o_reverse (w_rev[k]),
            .o_duty    (w_duty[k])
        );
    end

    // whole pipeline moves unless a held word waits at the output
    assign o_valid = r_wv[3];
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    assign o_wheel0_reverse = w_rev[0];
    assign o_wheel0_duty    = w_duty[0];
    assign o_wheel1_reverse = w_rev[1];
    assign o_wheel1_duty    = w_duty[1];
    assign o_wheel2_reverse = w_rev[2];
    assign o_wheel2_duty    = w_duty[2];
    assign o_wheel3_reverse = w_rev[3];
    assign o_wheel3_duty    = w_duty[3];

endmodule

`default_nettype wire
